[rtl/core/u8d_pkg.sv]
// Shared constants, types and lead byte decode for the UTF-8 byte stream decoder.
package u8d_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 31;
    localparam int LEN_W     = 3;
    localparam int PAYLOAD_W = 6;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    localparam logic [LEN_W-1:0] LEN_ASCII = 3'd1;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  payload;
    } lead_t;

    function automatic lead_t u8d_lead(input logic [BYTE_W-1:0] b);
        lead_t r;
        r = '0;
        unique case (b) inside
            8'b110?????: begin
                r.valid   = 1'b1;
                r.len     = 3'd2;
                r.payload = CP_W'(b[4:0]);
            end
            8'b1110????: begin
                r.valid   = 1'b1;
                r.len     = 3'd3;
                r.payload = CP_W'(b[3:0]);
            end
            8'b11110???: begin
                r.valid   = 1'b1;
                r.len     = 3'd4;
                r.payload = CP_W'(b[2:0]);
            end
            8'b111110??: begin
                r.valid   = 1'b1;
                r.len     = 3'd5;
                r.payload = CP_W'(b[1:0]);
            end
            8'b1111110?: begin
                r.valid   = 1'b1;
                r.len     = 3'd6;
                r.payload = CP_W'(b[0]);
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/core/utf8_byte_stream_decoder.sv]
// UTF-8 byte stream decoder top level: one byte in, one decode result out.
// Latency: a result appears on m_ the cycle after its byte transfer.
// Throughput: one byte per cycle unless m_ready stalls; state update is a shift-and-or.
// s_ready is high whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous): decode state cleared to zero, no result pending.
module utf8_byte_stream_decoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [u8d_pkg::BYTE_W-1:0] s_in_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_error,
    output logic                       m_complete,
    output logic [u8d_pkg::CP_W-1:0]   m_code_point,
    output logic [u8d_pkg::LEN_W-1:0]  m_seq_len
);
    import u8d_pkg::*;

    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [CP_W-1:0]  accum_reg, accum_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;

    logic             m_valid_reg;
    logic             m_error_reg;
    logic             m_complete_reg;
    logic [CP_W-1:0]  m_code_point_reg;
    logic [LEN_W-1:0] m_seq_len_reg;

    logic  accept;
    logic  err;
    lead_t lead;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        lead            = u8d_lead(s_in_byte);
        bytes_left_next = bytes_left_reg;
        accum_next      = accum_reg;
        cur_len_next    = cur_len_reg;
        err             = 1'b0;
        if (bytes_left_reg != '0) begin
            if ((s_in_byte & CONT_MASK) == CONT_TAG) begin
                accum_next      = {accum_reg[CP_W-PAYLOAD_W-1:0], s_in_byte[PAYLOAD_W-1:0]};
                bytes_left_next = bytes_left_reg - 1'b1;
            end else begin
                err = 1'b1;
            end
        end else if (!s_in_byte[BYTE_W-1]) begin
            accum_next   = CP_W'(s_in_byte);
            cur_len_next = LEN_ASCII;
        end else if (lead.valid) begin
            accum_next      = lead.payload;
            bytes_left_next = lead.len - 1'b1;
            cur_len_next    = lead.len;
        end else begin
            err = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            accum_reg      <= '0;
            cur_len_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                bytes_left_reg <= bytes_left_next;
                accum_reg      <= accum_next;
                cur_len_reg    <= cur_len_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_error_reg      <= err;
            m_complete_reg   <= !err && (bytes_left_next == '0);
            m_code_point_reg <= accum_next;
            m_seq_len_reg    <= cur_len_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_error      = m_error_reg;
    assign m_complete   = m_complete_reg;
    assign m_code_point = m_code_point_reg;
    assign m_seq_len    = m_seq_len_reg;

    // rejected byte leaves decode state untouched
    a_err_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && err) |=> ($stable(accum_reg) && $stable(bytes_left_reg)
                             && $stable(cur_len_reg)))
        else $error("decode state changed on rejected byte");

    a_left_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg != '0) |-> (bytes_left_reg < cur_len_reg))
        else $error("bytes left not below sequence length");

    a_complete_has_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_complete) |-> (!m_error && m_seq_len != '0))
        else $error("complete result without sequence length");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("transfer gave no result");

endmodule
